// ----- rtl/art_pkg.sv -----
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants of the acknowledgement retransmit tracker.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int ID_W      = 32;
    localparam int TIME_W    = 32;
    localparam int TMO_W     = 16;
    localparam int RETRY_W   = 4;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [TMO_W-1:0]   TIMEOUT_RESET = TMO_W'(200);
    localparam logic [RETRY_W-1:0] RETRY_RESET   = RETRY_W'(3);

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        REQ_SEND  = 2'd0,
        REQ_ACK   = 2'd1,
        REQ_CHECK = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        EV_TRANSMIT    = 3'd0,
        EV_RETRANSMIT  = 3'd1,
        EV_GIVE_UP     = 3'd2,
        EV_ACKED       = 3'd3,
        EV_ACK_UNKNOWN = 3'd4,
        EV_FULL        = 3'd5,
        EV_DONE        = 3'd6
    } ev_t;

    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_step;
        logic adv_prev;
        logic write_send;
        logic remove_match;
        logic apply_best;
        logic emit;
        ev_t  ev;
    } ctl_cmd_t;

    typedef struct packed {
        req_t req_type;
        logic scan_last;
        logic match_found;
        logic free_found;
        logic best_found;
        logic timed_out;
        logic retry_ok;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/art_ctrl.sv -----
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer: table scans per request, decisions and result emission.
// ----------------------------------------------------------------------------
module art_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  art_pkg::req_t     in_req,
    output logic              s_tready,
    input  art_pkg::dp_stat_t st,
    output art_pkg::ctl_cmd_t cmd
);
    import art_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEND,
        ST_ACK,
        ST_CHECK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_tready_reg;
    logic   accept;

    assign accept   = s_tvalid && s_tready_reg;
    assign s_tready = s_tready_reg;

    always_comb begin
        cmd        = '0;
        cmd.ev     = EV_DONE;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    if (in_req == REQ_SEND || in_req == REQ_ACK || in_req == REQ_CHECK) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (st.scan_last) begin
                    unique case (st.req_type)
                        REQ_SEND: state_next = ST_SEND;
                        REQ_ACK:  state_next = ST_ACK;
                        default:  state_next = ST_CHECK;
                    endcase
                end
            end
            ST_SEND: begin
                if (st.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.write_send = st.match_found || st.free_found;
                    cmd.ev         = (st.match_found || st.free_found) ? EV_TRANSMIT : EV_FULL;
                    state_next     = ST_IDLE;
                end
            end
            ST_ACK: begin
                if (st.out_free) begin
                    cmd.emit         = 1'b1;
                    cmd.remove_match = st.match_found;
                    cmd.ev           = st.match_found ? EV_ACKED : EV_ACK_UNKNOWN;
                    state_next       = ST_IDLE;
                end
            end
            ST_CHECK: begin
                if (!st.best_found) begin
                    if (st.out_free) begin
                        cmd.emit   = 1'b1;
                        cmd.ev     = EV_DONE;
                        state_next = ST_IDLE;
                    end
                end else if (!st.timed_out) begin
                    cmd.adv_prev = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_SCAN;
                end else if (st.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.apply_best = 1'b1;
                    cmd.adv_prev   = 1'b1;
                    cmd.scan_clr   = 1'b1;
                    cmd.ev         = st.retry_ok ? EV_RETRANSMIT : EV_GIVE_UP;
                    state_next     = ST_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
        end
    end

`ifndef ASSERT_OFF
    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> st.out_free)
        else $error("result emitted while output register occupied");
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=> !s_tready_reg || (state_reg == ST_IDLE))
        else $error("input ready during table scan");
    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && st.scan_last) |=> state_reg != ST_SCAN)
        else $error("scan did not end on last entry");
`endif

endmodule

// ----- rtl/art_datapath.sv -----
// ----------------------------------------------------------------------------
// art_datapath
// Entry table, configuration registers, scan registers and output register.
// ----------------------------------------------------------------------------
module art_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  art_pkg::ctl_cmd_t               cmd,
    output art_pkg::dp_stat_t               st,
    input  art_pkg::req_t                   in_req,
    input  logic [art_pkg::ID_W-1:0]        in_id,
    input  logic [art_pkg::TIME_W-1:0]      in_now,
    input  logic                            cfg_we,
    input  logic [art_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [art_pkg::CFG_DAT_W-1:0]   cfg_wdata,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output art_pkg::ev_t                    m_ev,
    output logic [art_pkg::ID_W-1:0]        m_id,
    output logic [art_pkg::RETRY_W-1:0]     m_attempt,
    output logic                            m_last
);
    import art_pkg::*;

    logic [TMO_W-1:0]   timeout_reg;
    logic [RETRY_W-1:0] max_retries_reg;
    logic [ID_W-1:0]    next_auto_reg;
    logic [ID_W-1:0]    next_auto_inc;

    logic               valid_reg   [TABLE_DEPTH];
    logic [ID_W-1:0]    id_reg      [TABLE_DEPTH];
    logic [TIME_W-1:0]  stamp_reg   [TABLE_DEPTH];
    logic [RETRY_W-1:0] retries_reg [TABLE_DEPTH];

    req_t               req_reg;
    logic [ID_W-1:0]    req_id_reg;
    logic [TIME_W-1:0]  now_reg;

    logic [IDX_W-1:0]   idx_reg;
    logic               match_found_reg;
    logic [IDX_W-1:0]   match_slot_reg;
    logic [RETRY_W-1:0] match_retries_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_slot_reg;
    logic               best_found_reg;
    logic [IDX_W-1:0]   best_slot_reg;
    logic [ID_W-1:0]    best_id_reg;
    logic [TIME_W-1:0]  best_stamp_reg;
    logic [RETRY_W-1:0] best_retries_reg;
    logic               have_prev_reg;
    logic [ID_W-1:0]    prev_id_reg;

    logic               out_valid_reg;
    ev_t                out_ev_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [RETRY_W-1:0] out_att_reg;
    logic               out_last_reg;

    logic               e_valid;
    logic [ID_W-1:0]    e_id;
    logic [TIME_W-1:0]  e_stamp;
    logic [RETRY_W-1:0] e_retries;
    logic [TIME_W-1:0]  elapsed;
    logic               out_free;
    logic               better;
    logic [IDX_W-1:0]   wslot;

    assign e_valid   = valid_reg[idx_reg];
    assign e_id      = id_reg[idx_reg];
    assign e_stamp   = stamp_reg[idx_reg];
    assign e_retries = retries_reg[idx_reg];

    assign elapsed       = now_reg - best_stamp_reg;
    assign out_free      = !out_valid_reg || m_tready;
    assign next_auto_inc = next_auto_reg + ID_W'(1);
    assign wslot         = match_found_reg ? match_slot_reg : free_slot_reg;
    assign better        = e_valid && (!have_prev_reg || e_id > prev_id_reg)
                           && (!best_found_reg || e_id < best_id_reg);

    always_comb begin
        st.req_type    = req_reg;
        st.scan_last   = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
        st.match_found = match_found_reg;
        st.free_found  = free_found_reg;
        st.best_found  = best_found_reg;
        st.timed_out   = elapsed > {{(TIME_W-TMO_W){1'b0}}, timeout_reg};
        st.retry_ok    = best_retries_reg < max_retries_reg;
        st.out_free    = out_free;
    end

    // configuration, request capture and auto id
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg     <= TIMEOUT_RESET;
            max_retries_reg <= RETRY_RESET;
            next_auto_reg   <= ID_W'(1);
        end else begin
            if (cfg_we && cfg_addr == CFG_TIMEOUT) begin
                timeout_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == CFG_MAX_RETRIES) begin
                max_retries_reg <= cfg_wdata[RETRY_W-1:0];
            end
            if (cmd.load && in_req == REQ_SEND && in_id == '0) begin
                next_auto_reg <= (next_auto_inc == '0) ? ID_W'(1) : next_auto_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg    <= in_req;
            req_id_reg <= (in_req == REQ_SEND && in_id == '0) ? next_auto_reg : in_id;
            now_reg    <= in_now;
        end
    end

    // scan registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
            have_prev_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                have_prev_reg <= 1'b0;
            end else if (cmd.adv_prev) begin
                have_prev_reg <= 1'b1;
            end
            if (cmd.scan_clr) begin
                idx_reg         <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                best_found_reg  <= 1'b0;
            end else if (cmd.scan_step) begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (e_valid && e_id == req_id_reg && !match_found_reg) begin
                    match_found_reg <= 1'b1;
                end
                if (!e_valid && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
                if (better) begin
                    best_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.adv_prev) begin
            prev_id_reg <= best_id_reg;
        end
        if (cmd.scan_step) begin
            if (e_valid && e_id == req_id_reg && !match_found_reg) begin
                match_slot_reg    <= idx_reg;
                match_retries_reg <= e_retries;
            end
            if (!e_valid && !free_found_reg) begin
                free_slot_reg <= idx_reg;
            end
            if (better) begin
                best_slot_reg    <= idx_reg;
                best_id_reg      <= e_id;
                best_stamp_reg   <= e_stamp;
                best_retries_reg <= e_retries;
            end
        end
    end

    // entry table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            if (cmd.write_send) begin
                valid_reg[wslot] <= 1'b1;
            end
            if (cmd.remove_match) begin
                valid_reg[match_slot_reg] <= 1'b0;
            end
            if (cmd.apply_best && !st.retry_ok) begin
                valid_reg[best_slot_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_send) begin
            id_reg[wslot]      <= req_id_reg;
            stamp_reg[wslot]   <= now_reg;
            retries_reg[wslot] <= '0;
        end
        if (cmd.apply_best && st.retry_ok) begin
            stamp_reg[best_slot_reg]   <= now_reg;
            retries_reg[best_slot_reg] <= best_retries_reg + RETRY_W'(1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_ev_reg <= cmd.ev;
            unique case (cmd.ev)
                EV_RETRANSMIT: begin
                    out_id_reg   <= best_id_reg;
                    out_att_reg  <= best_retries_reg + RETRY_W'(1);
                    out_last_reg <= 1'b0;
                end
                EV_GIVE_UP: begin
                    out_id_reg   <= best_id_reg;
                    out_att_reg  <= best_retries_reg;
                    out_last_reg <= 1'b0;
                end
                EV_ACKED: begin
                    out_id_reg   <= req_id_reg;
                    out_att_reg  <= match_retries_reg;
                    out_last_reg <= 1'b1;
                end
                EV_DONE: begin
                    out_id_reg   <= '0;
                    out_att_reg  <= '0;
                    out_last_reg <= 1'b1;
                end
                default: begin
                    out_id_reg   <= req_id_reg;
                    out_att_reg  <= '0;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign m_ev      = out_ev_reg;
    assign m_id      = out_id_reg;
    assign m_attempt = out_att_reg;
    assign m_last    = out_last_reg;

`ifndef ASSERT_OFF
    a_auto_id_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        next_auto_reg != '0)
        else $error("auto id counter reached zero");
    a_write_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_send |-> (match_found_reg || free_found_reg))
        else $error("table write without a slot");
    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> out_valid_reg)
        else $error("emitted result not presented");
    a_apply_has_best: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply_best |-> best_found_reg && valid_reg[best_slot_reg])
        else $error("check applied to an empty entry");
`endif

endmodule

// ----- rtl/ack_retransmit_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// ack_retransmit_tracker_unit
// Table of commands that await acknowledgement, with timeout retransmission.
// ----------------------------------------------------------------------------
// Input beats on s_*: tuser is the request kind (send, ack, check), tdata the
// command id and the current time. Result beats leave on m_*: tuser is the
// event code, tdata the id and attempt, tlast marks the final result of a
// request. Registers timeout and retry limit must be written on cfg_* only at
// idle by the user; the block itself does not enforce it. Every request scans
// the 16-entry table one entry per cycle through a single read port. A send or
// ack scans the table, then decides and registers its result; the decision
// waits while the output register is occupied, and the next beat is taken once
// it is made. A check selects entries in ascending id order with one full scan
// per selection, and waits whenever the receiver holds a waiting result back.
// Reset empties the table, sets the auto id to 1 and restores the registers;
// no clearing pass is needed. When the receiver stalls, the single output
// register holds its beat and the sequencer waits before the next result.
// ----------------------------------------------------------------------------
module ack_retransmit_tracker_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,  // cmd_id[31:0], now_ms[63:32]
    input  logic [1:0]                      s_tuser,  // req_type[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [39:0]                     m_tdata,  // result_id[31:0], attempt[35:32], 0
    output logic [2:0]                      m_tuser,  // event_code[2:0]
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [art_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [art_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
    import art_pkg::*;

    ctl_cmd_t           cmd;
    dp_stat_t           st;
    req_t               in_req;
    ev_t                m_ev;
    logic [ID_W-1:0]    m_id;
    logic [RETRY_W-1:0] m_attempt;

    assign in_req    = req_t'(s_tuser);
    assign cfg_ready = 1'b1;
    assign m_tuser   = m_ev;
    assign m_tdata   = {4'b0000, m_attempt, m_id};

    art_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_req   (in_req),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    art_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .in_req    (in_req),
        .in_id     (s_tdata[31:0]),
        .in_now    (s_tdata[63:32]),
        .cfg_we    (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_ev      (m_ev),
        .m_id      (m_id),
        .m_attempt (m_attempt),
        .m_last    (m_tlast)
    );

endmodule
